// ===== rtl/zvwd_pkg.sv =====
package zvwd_pkg;

    // Default build parameters
    localparam int WINDOW_DEFAULT      = 16;
    localparam int SAMPLE_BITS_DEFAULT = 32;

    // Field and port widths
    localparam int FIELD_W     = 32;
    localparam int SPREAD_W    = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int HOLD_W      = 8;
    localparam int AXES        = 6;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DETECT_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_LIMIT    = 2'd3;

    // Register reset values
    localparam logic              DETECT_ENABLE_RST = 1'b1;
    localparam logic [CFG_W-1:0]  ACCEL_LIMIT_RST   = 32'd32768;
    localparam logic [CFG_W-1:0]  SPEED_LIMIT_RST   = 32'd6554;
    localparam logic [CFG_W-1:0]  GYRO_LIMIT_RST    = 32'd655;

    // Hold counter limits
    localparam logic [HOLD_W-1:0] HOLD_MAX         = 8'd255;
    localparam logic [HOLD_W-1:0] HOLD_READY_COUNT = 8'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SPREAD,
        ST_DECIDE
    } state_t;

    // Controls from the sequencer to the scan unit
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic load;
        logic first;
        logic spread;
    } scan_ctrl_t;

endpackage

// ===== rtl/zvwd_in_if.sv =====
interface zvwd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] wheel_speed;
    logic               evaluate;

    modport source (
        output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
               wheel_speed, evaluate,
        input  ready
    );
    modport sink (
        input  valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
               wheel_speed, evaluate,
        output ready
    );
endinterface

// ===== rtl/zvwd_out_if.sv =====
interface zvwd_out_if;
    logic        valid;
    logic        ready;
    logic        decided;
    logic        standstill;
    logic [7:0]  hold_count;
    logic        heading_hold_ready;
    logic [31:0] gyro_spread;
    logic [31:0] accel_spread;

    modport source (
        output valid, decided, standstill, hold_count, heading_hold_ready,
               gyro_spread, accel_spread,
        input  ready
    );
    modport sink (
        input  valid, decided, standstill, hold_count, heading_hold_ready,
               gyro_spread, accel_spread,
        output ready
    );
endinterface

// ===== rtl/zvwd_scan_unit.sv =====
module zvwd_scan_unit
    import zvwd_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  scan_ctrl_t                      ctrl,
    input  logic [$clog2(WINDOW)-1:0]       wr_addr,
    input  logic [$clog2(WINDOW)-1:0]       rd_addr,
    input  logic [AXES*SAMPLE_BITS-1:0]     wr_data,
    output logic [SPREAD_W-1:0]             gyro_spread,
    output logic [SPREAD_W-1:0]             accel_spread
);

    localparam int SB    = SAMPLE_BITS;
    localparam int ROW_W = AXES * SB;

    logic [ROW_W-1:0]          window_mem [WINDOW];
    logic [ROW_W-1:0]          rd_data_reg;
    logic signed [SB-1:0]      max_reg [AXES];
    logic signed [SB-1:0]      min_reg [AXES];
    logic [SPREAD_W-1:0]       lane_spread [AXES];
    logic [SPREAD_W-1:0]       gyro_best;
    logic [SPREAD_W-1:0]       accel_best;
    logic [SPREAD_W-1:0]       gyro_spread_reg;
    logic [SPREAD_W-1:0]       accel_spread_reg;

    // Sample window: one row write, one registered row read per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            window_mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= window_mem[rd_addr];
        end
    end

    // Per-axis running max / min, seeded from the first row read
    for (genvar k = 0; k < AXES; k++)
    begin : g_lane
        logic signed [SB-1:0] s;
        logic signed [SB:0]   diff;
        logic [SB-1:0]        mag;

        assign s = signed'(rd_data_reg[k*SB +: SB]);

        always_ff @(posedge clk)
        begin
            if (ctrl.load)
            begin
                if (ctrl.first || s > max_reg[k])
                begin
                    max_reg[k] <= s;
                end
                if (ctrl.first || s < min_reg[k])
                begin
                    min_reg[k] <= s;
                end
            end
        end

        // max - min is never negative and fits SB unsigned bits
        assign diff = {max_reg[k][SB-1], max_reg[k]} - {min_reg[k][SB-1], min_reg[k]};
        assign mag  = diff[SB-1:0];

        if (SB > SPREAD_W)
        begin : g_sat
            assign lane_spread[k] = (|mag[SB-1:SPREAD_W]) ? '1 : mag[SPREAD_W-1:0];
        end
        else
        begin : g_ext
            assign lane_spread[k] = SPREAD_W'(mag);
        end
    end

    // Largest spread per sensor group
    always_comb
    begin
        gyro_best = lane_spread[0];
        if (lane_spread[1] > gyro_best)
        begin
            gyro_best = lane_spread[1];
        end
        if (lane_spread[2] > gyro_best)
        begin
            gyro_best = lane_spread[2];
        end
        accel_best = lane_spread[3];
        if (lane_spread[4] > accel_best)
        begin
            accel_best = lane_spread[4];
        end
        if (lane_spread[5] > accel_best)
        begin
            accel_best = lane_spread[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.spread)
        begin
            gyro_spread_reg  <= gyro_best;
            accel_spread_reg <= accel_best;
        end
    end

    assign gyro_spread  = gyro_spread_reg;
    assign accel_spread = accel_spread_reg;

endmodule

// ===== rtl/zvwd_ctrl.sv =====
module zvwd_ctrl
    import zvwd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    zvwd_in_if.sink                     in_ch,
    zvwd_out_if.source                  out_ch,
    input  logic [SPREAD_W-1:0]         gyro_spread,
    input  logic [SPREAD_W-1:0]         accel_spread,
    output scan_ctrl_t                  sc,
    output logic [$clog2(WINDOW)-1:0]   wr_addr,
    output logic [$clog2(WINDOW)-1:0]   rd_addr
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SLOT_W-1:0]   scan_reg, scan_next;
    logic                full_reg, full_next;
    logic                speed_low_reg, speed_low_next;
    logic                rd_valid_reg, rd_first_reg;

    logic                enable_reg;
    logic [CFG_W-1:0]    accel_limit_reg, speed_limit_reg, gyro_limit_reg;

    logic                stand_reg, stand_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                ready_flag_reg, ready_flag_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_decided_reg;
    logic [SPREAD_W-1:0] out_gyro_reg, out_accel_reg;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic [FIELD_W-1:0]  abs_speed;
    logic                fill_at_end;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= DETECT_ENABLE_RST;
            accel_limit_reg <= ACCEL_LIMIT_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
            gyro_limit_reg  <= GYRO_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DETECT_ENABLE: enable_reg      <= cfg_data[0];
                CFG_ACCEL_LIMIT:   accel_limit_reg <= cfg_data;
                CFG_SPEED_LIMIT:   speed_limit_reg <= cfg_data;
                CFG_GYRO_LIMIT:    gyro_limit_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Requests are taken only while idle
    assign in_ch.ready = (state_reg == ST_IDLE);

    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign abs_speed   = in_ch.wheel_speed[FIELD_W-1] ? (~in_ch.wheel_speed + 1'b1)
                                                     : in_ch.wheel_speed;
    // Window is full once this request's row is stored
    assign fill_at_end = (fill_reg >= FULL_FILL - 1'b1);

    // Sequencer: next state and controls
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        full_next      = full_reg;
        speed_low_next = speed_low_reg;
        load_out       = 1'b0;
        sc             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sc.wr_en  = 1'b1;
                    slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    if (fill_reg < FULL_FILL)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (in_ch.evaluate)
                    begin
                        full_next      = fill_at_end;
                        speed_low_next = (abs_speed < speed_limit_reg);
                        scan_next      = '0;
                        state_next     = fill_at_end ? ST_SCAN : ST_DECIDE;
                    end
                end
            end
            ST_SCAN:
            begin
                sc.rd_en  = 1'b1;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SPREAD;
            end
            ST_SPREAD:
            begin
                sc.spread  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        sc.load  = rd_valid_reg;
        sc.first = rd_first_reg;
    end

    assign wr_addr = slot_reg;
    assign rd_addr = scan_reg;

    // Standstill decision
    always_comb
    begin
        stand_next      = stand_reg;
        hold_next       = hold_reg;
        ready_flag_next = ready_flag_reg;
        if (full_reg)
        begin
            if (enable_reg)
            begin
                if (accel_spread < accel_limit_reg && speed_low_reg)
                begin
                    stand_next = 1'b1;
                    if (gyro_spread < gyro_limit_reg)
                    begin
                        if (hold_reg < HOLD_MAX)
                        begin
                            hold_next = hold_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        hold_next = '0;
                    end
                end
                else
                begin
                    stand_next      = 1'b0;
                    hold_next       = '0;
                    ready_flag_next = 1'b0;
                end
            end
            if (hold_next >= HOLD_READY_COUNT)
            begin
                ready_flag_next = 1'b1;
            end
        end
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            fill_reg       <= '0;
            scan_reg       <= '0;
            full_reg       <= 1'b0;
            speed_low_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            stand_reg      <= 1'b0;
            hold_reg       <= '0;
            ready_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            full_reg      <= full_next;
            speed_low_reg <= speed_low_next;
            rd_valid_reg  <= sc.rd_en;
            rd_first_reg  <= sc.rd_en && (scan_reg == '0);
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                stand_reg      <= stand_next;
                hold_reg       <= hold_next;
                ready_flag_reg <= ready_flag_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_decided_reg <= full_reg;
            out_gyro_reg    <= full_reg ? gyro_spread : '0;
            out_accel_reg   <= full_reg ? accel_spread : '0;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.decided            = out_decided_reg;
    assign out_ch.standstill         = stand_reg;
    assign out_ch.hold_count         = hold_reg;
    assign out_ch.heading_hold_ready = ready_flag_reg;
    assign out_ch.gyro_spread        = out_gyro_reg;
    assign out_ch.accel_spread       = out_accel_reg;

endmodule

// ===== rtl/zero_velocity_window_detector_top.sv =====
// Zero-velocity detector. Every request stores one IMU sample (gyro and accel
// triples, saturated to SAMPLE_BITS) into a circular window of WINDOW rows.
// A request without evaluate returns nothing. An evaluate request on a window
// that is not yet full skips the scan and returns decided = 0. An evaluate
// request on a full window is scanned: the window memory has one read port,
// so the max/min lanes see one row per cycle, followed by a drain, a spread
// and a decision step. The input side is not ready while an item is in work;
// a finished result waits in the output register without holding up the next
// request. The user must write configuration through cfg_we / cfg_index /
// cfg_data only while the block is idle; the block does not enforce this.
module zero_velocity_window_detector_top
    import zvwd_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    zvwd_in_if.sink                in_ch,
    zvwd_out_if.source             out_ch
);

    localparam int SB     = SAMPLE_BITS;
    localparam int SLOT_W = $clog2(WINDOW);

    logic signed [FIELD_W-1:0] axis_in [AXES];
    logic [AXES*SB-1:0]        row_data;
    scan_ctrl_t                sc;
    logic [SLOT_W-1:0]         wr_addr, rd_addr;
    logic [SPREAD_W-1:0]       gyro_spread, accel_spread;

    assign axis_in[0] = in_ch.gyro_x;
    assign axis_in[1] = in_ch.gyro_y;
    assign axis_in[2] = in_ch.gyro_z;
    assign axis_in[3] = in_ch.accel_x;
    assign axis_in[4] = in_ch.accel_y;
    assign axis_in[5] = in_ch.accel_z;

    // Fit each axis to the stored sample width
    for (genvar k = 0; k < AXES; k++)
    begin : g_fit
        if (SB >= FIELD_W)
        begin : g_wide
            assign row_data[k*SB +: SB] = SB'(axis_in[k]);
        end
        else
        begin : g_narrow
            localparam logic signed [FIELD_W-1:0] SAT_HI =
                (32'sd1 <<< (SB - 1)) - 32'sd1;
            localparam logic signed [FIELD_W-1:0] SAT_LO = -SAT_HI - 32'sd1;

            assign row_data[k*SB +: SB] =
                (axis_in[k] > SAT_HI) ? SAT_HI[SB-1:0] :
                (axis_in[k] < SAT_LO) ? SAT_LO[SB-1:0] :
                                        axis_in[k][SB-1:0];
        end
    end

    zvwd_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .gyro_spread  (gyro_spread),
        .accel_spread (accel_spread),
        .sc           (sc),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    zvwd_scan_unit #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .clk          (clk),
        .ctrl         (sc),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .wr_data      (row_data),
        .gyro_spread  (gyro_spread),
        .accel_spread (accel_spread)
    );

endmodule

// ===== tb/zero_velocity_window_detector_top_tb.sv =====
`timescale 1ns / 100ps

module zero_velocity_window_detector_top_tb;
    import zvwd_pkg::*;

    localparam int WIN           = WINDOW_DEFAULT;
    localparam int SETTLE_CYCLES = WIN + 8;

    // One IMU sample as presented on the request channel
    typedef struct packed {
        logic signed [FIELD_W-1:0] gyro_x;
        logic signed [FIELD_W-1:0] gyro_y;
        logic signed [FIELD_W-1:0] gyro_z;
        logic signed [FIELD_W-1:0] accel_x;
        logic signed [FIELD_W-1:0] accel_y;
        logic signed [FIELD_W-1:0] accel_z;
        logic signed [FIELD_W-1:0] wheel_speed;
        logic                      evaluate;
    } imu_sample_t;

    // One standstill decision as returned on the result channel
    typedef struct packed {
        logic                decided;
        logic                standstill;
        logic [HOLD_W-1:0]   hold_count;
        logic                heading_hold_ready;
        logic [SPREAD_W-1:0] gyro_spread;
        logic [SPREAD_W-1:0] accel_spread;
    } decision_t;

    typedef struct packed {
        imu_sample_t sample;
        logic [7:0]  reps;
        logic        typed;
        decision_t   want;
    } stim_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_LONG
    } stall_mode_t;

    localparam decision_t NO_CHECK = '0;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    zvwd_in_if  in_ch ();
    zvwd_out_if out_ch ();

    zero_velocity_window_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: register copies, sample window and flags
    logic                      pr_detect     = DETECT_ENABLE_RST;
    logic [CFG_W-1:0]          pr_accel_lim  = ACCEL_LIMIT_RST;
    logic [CFG_W-1:0]          pr_speed_lim  = SPEED_LIMIT_RST;
    logic [CFG_W-1:0]          pr_gyro_lim   = GYRO_LIMIT_RST;
    logic signed [FIELD_W-1:0] sample_hist [2][WIN][3];
    int                        next_slot     = 0;
    int                        fill_level    = 0;
    logic                      still_flag    = 1'b0;
    logic [HOLD_W-1:0]         hold_cnt      = '0;
    logic                      hold_ready    = 1'b0;

    decision_t   pending_decisions [$];
    stim_row_t   dir_tab [$];
    int          fail_count        = 0;
    int          items_sent        = 0;
    int          decisions_checked = 0;
    int          settings_applied  = 0;
    int          burst_left        = 0;

    // Random sequence state: per-axis base, noise amplitudes, run length
    logic [FIELD_W-1:0] seq_base [6];
    int                 seq_left  = 0;
    int                 gyro_amp  = 0;
    int                 accel_amp = 0;
    int                 speed_amp = 0;

    // Widest per-axis max-min over the window; sensor 0 gyro, 1 accel
    function automatic logic [SPREAD_W-1:0] spread_of(input int sensor);
        longint hi;
        longint lo;
        longint widest;
        widest = 0;
        for (int a = 0; a < 3; a++)
        begin
            hi = sample_hist[sensor][0][a];
            lo = hi;
            for (int i = 1; i < WIN; i++)
            begin
                if (sample_hist[sensor][i][a] > hi) hi = sample_hist[sensor][i][a];
                if (sample_hist[sensor][i][a] < lo) lo = sample_hist[sensor][i][a];
            end
            if (hi - lo > widest) widest = hi - lo;
        end
        return widest[SPREAD_W-1:0];
    endfunction

    // Store the sample and work out the decision it causes, if any.
    // Samples are full width here, so no saturation on store.
    function automatic decision_t predict_decision(input imu_sample_t s, output bit makes);
        decision_t d;
        longint    spd;
        longint    spd_mag;
        d = '0;
        sample_hist[0][next_slot][0] = s.gyro_x;
        sample_hist[0][next_slot][1] = s.gyro_y;
        sample_hist[0][next_slot][2] = s.gyro_z;
        sample_hist[1][next_slot][0] = s.accel_x;
        sample_hist[1][next_slot][1] = s.accel_y;
        sample_hist[1][next_slot][2] = s.accel_z;
        next_slot = (next_slot + 1) % WIN;
        if (fill_level < WIN) fill_level++;
        makes = s.evaluate;
        if (s.evaluate && fill_level >= WIN)
        begin
            d.decided      = 1'b1;
            d.gyro_spread  = spread_of(0);
            d.accel_spread = spread_of(1);
            spd     = s.wheel_speed;
            spd_mag = (spd < 0) ? -spd : spd;
            if (pr_detect)
            begin
                if (d.accel_spread < pr_accel_lim && spd_mag < longint'(pr_speed_lim))
                begin
                    still_flag = 1'b1;
                    if (d.gyro_spread < pr_gyro_lim)
                    begin
                        if (hold_cnt < HOLD_MAX) hold_cnt++;
                    end
                    else
                        hold_cnt = '0;
                end
                else
                begin
                    still_flag = 1'b0;
                    hold_cnt   = '0;
                    hold_ready = 1'b0;
                end
            end
            if (hold_cnt >= HOLD_READY_COUNT) hold_ready = 1'b1;
        end
        d.standstill         = still_flag;
        d.hold_count         = hold_cnt;
        d.heading_hold_ready = hold_ready;
        return d;
    endfunction

    function automatic imu_sample_t imu(input logic [31:0] gx, gy, gz, ax, ay, az, spd,
                                        input bit ev);
        imu_sample_t s;
        s = '{gx, gy, gz, ax, ay, az, spd, ev};
        return s;
    endfunction

    function automatic decision_t dec(input bit dcd, ss, input int hold, input bit rdy,
                                      input logic [31:0] gsp, asp);
        decision_t d;
        d = '{dcd, ss, hold[HOLD_W-1:0], rdy, gsp, asp};
        return d;
    endfunction

    function automatic stim_row_t row(input imu_sample_t s, input int reps, input bit typed,
                                      input decision_t want);
        stim_row_t r;
        r = '{s, reps[7:0], typed, want};
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] jitter(input logic [FIELD_W-1:0] base,
                                                  input int amp);
        return base + 32'($urandom_range(0, 2 * amp)) - 32'(amp);
    endfunction

    function automatic int pick_amp(input bit calm);
        int sel;
        sel = calm ? 0 : $urandom_range(0, 2);
        case (sel)
            0:       return $urandom_range(0, 300);
            1:       return $urandom_range(0, 20000);
            default: return $urandom_range(0, 1 << 20);
        endcase
    endfunction

    // Runs of samples around a held base with random noise, plus raw noise
    function automatic imu_sample_t next_sample(input int eval_pct, input bit calm);
        imu_sample_t s;
        if (seq_left == 0)
        begin
            seq_left = $urandom_range(8, 40);
            for (int k = 0; k < 6; k++)
                seq_base[k] = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : jitter('0, 1000);
            gyro_amp  = pick_amp(calm);
            accel_amp = pick_amp(calm);
            speed_amp = $urandom_range(0, 1) ? 3000 : 9000;
        end
        seq_left--;
        if (!calm && $urandom_range(0, 9) == 0)
            s = imu($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
        else
            s = imu(jitter(seq_base[0], gyro_amp), jitter(seq_base[1], gyro_amp),
                    jitter(seq_base[2], gyro_amp), jitter(seq_base[3], accel_amp),
                    jitter(seq_base[4], accel_amp), jitter(seq_base[5], accel_amp),
                    jitter('0, speed_amp), 1'b0);
        s.evaluate = ($urandom_range(0, 99) < eval_pct);
        return s;
    endfunction

    // Sender pacing: bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 9);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_sample(input imu_sample_t s, input bit typed, input decision_t want);
        decision_t predicted;
        bit        makes;
        pace_sender();
        in_ch.valid       <= 1'b1;
        in_ch.gyro_x      <= s.gyro_x;
        in_ch.gyro_y      <= s.gyro_y;
        in_ch.gyro_z      <= s.gyro_z;
        in_ch.accel_x     <= s.accel_x;
        in_ch.accel_y     <= s.accel_y;
        in_ch.accel_z     <= s.accel_z;
        in_ch.wheel_speed <= s.wheel_speed;
        in_ch.evaluate    <= s.evaluate;
        do @(posedge clk); while (!in_ch.ready);
        predicted = predict_decision(s, makes);
        if (makes) pending_decisions.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Hold off requests until every decision is back and the block is quiet
    task automatic settle_pipeline();
        in_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_DETECT_ENABLE: pr_detect    = data[0];
            CFG_ACCEL_LIMIT:   pr_accel_lim = data;
            CFG_SPEED_LIMIT:   pr_speed_lim = data;
            CFG_GYRO_LIMIT:    pr_gyro_lim  = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input bit detect, input logic [CFG_W-1:0] accel_lim,
                                  input logic [CFG_W-1:0] speed_lim,
                                  input logic [CFG_W-1:0] gyro_lim);
        write_reg(CFG_DETECT_ENABLE, CFG_W'(detect));
        write_reg(CFG_ACCEL_LIMIT, accel_lim);
        write_reg(CFG_SPEED_LIMIT, speed_lim);
        write_reg(CFG_GYRO_LIMIT, gyro_lim);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    task automatic run_random(input int count, input int eval_pct, input bit calm);
        for (int i = 0; i < count; i++)
            send_sample(next_sample(eval_pct, calm), 1'b0, NO_CHECK);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        decision_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_decisions.size() == 0)
            begin
                $error("decision returned with no request waiting for one");
                fail_count++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                check_field("decided", want.decided, out_ch.decided);
                check_field("standstill", want.standstill, out_ch.standstill);
                check_field("hold_count", want.hold_count, out_ch.hold_count);
                check_field("heading_hold_ready", want.heading_hold_ready,
                            out_ch.heading_hold_ready);
                check_field("gyro_spread", want.gyro_spread, out_ch.gyro_spread);
                check_field("accel_spread", want.accel_spread, out_ch.accel_spread);
                decisions_checked++;
            end
        end
    end

    // Receiver stalls: switches between several patterns, each held for a random stretch
    initial
    begin : result_stall
        stall_mode_t mode;
        int          left;
        int          tick;
        int          stall_left;
        mode       = STALL_NONE;
        left       = 0;
        tick       = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(50, 300);
            end
            left--;
            tick++;
            case (mode)
                STALL_NONE:     out_ch.ready <= 1'b1;
                STALL_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: out_ch.ready <= ((tick % 7) >= 3);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        out_ch.ready <= 1'b0;
                        stall_left--;
                    end
                    else
                    begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(10, 40);
                    end
                end
            endcase
        end
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_DETECT_ENABLE;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.gyro_x      <= '0;
        in_ch.gyro_y      <= '0;
        in_ch.gyro_z      <= '0;
        in_ch.accel_x     <= '0;
        in_ch.accel_y     <= '0;
        in_ch.accel_z     <= '0;
        in_ch.wheel_speed <= '0;
        in_ch.evaluate    <= 1'b0;

        // Directed table at reset settings.
        // Window not yet full: nothing decided, flags still clear
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 0, 1), 1, 1, dec(0, 0, 0, 0, 0, 0)));
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 0, 0), 14, 0, NO_CHECK));
        // Window just full, all quiet: hold climbs, ready sets at two
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 0, 1), 1, 1, dec(1, 1, 1, 0, 0, 0)));
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 0, 1), 1, 1, dec(1, 1, 2, 1, 0, 0)));
        // Gyro extremes: hold drops, ready kept while still
        dir_tab.push_back(row(imu(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1), 1, 1,
                              dec(1, 1, 0, 1, 32'h7FFF_FFFF, 0)));
        dir_tab.push_back(row(imu(0, 32'h8000_0000, 0, 0, 0, 0, 0, 1), 1, 1,
                              dec(1, 1, 0, 1, 32'h8000_0000, 0)));
        dir_tab.push_back(row(imu(0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 1, 0, NO_CHECK));
        dir_tab.push_back(row(imu(0, 0, 32'h8000_0000, 0, 0, 0, 0, 1), 1, 1,
                              dec(1, 1, 0, 1, 32'hFFFF_FFFF, 0)));
        // Wheel speed extremes and the limit boundary
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 32'h8000_0000, 1), 1, 1,
                              dec(1, 0, 0, 0, 32'hFFFF_FFFF, 0)));
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1), 1, 1,
                              dec(1, 0, 0, 0, 32'hFFFF_FFFF, 0)));
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 6553, 1), 1, 1,
                              dec(1, 1, 0, 0, 32'hFFFF_FFFF, 0)));
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 0, 32'hFFFF_E666, 1), 1, 1,
                              dec(1, 0, 0, 0, 32'hFFFF_FFFF, 0)));
        // Accel extremes
        dir_tab.push_back(row(imu(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1), 1, 1,
                              dec(1, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000)));
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 32'h8000_0000, 0, 0), 1, 0, NO_CHECK));
        dir_tab.push_back(row(imu(0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 1), 1, 1,
                              dec(1, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF)));
        // Bit patterns, left to the predictor
        dir_tab.push_back(row(imu('1, '1, '1, '1, '1, '1, '1, 1), 1, 0, NO_CHECK));
        dir_tab.push_back(row(imu({16{2'b01}}, {16{2'b10}}, {16{2'b01}}, {16{2'b10}},
                                  {16{2'b01}}, {16{2'b10}}, 32'h0000_5555, 1), 1, 0,
                              NO_CHECK));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
            for (int k = 0; k < dir_tab[r].reps; k++)
                send_sample(dir_tab[r].sample, dir_tab[r].typed, dir_tab[r].want);
        settle_pipeline();

        // Reset limits, mixed traffic, with one full drain in the middle
        apply_settings(1'b1, ACCEL_LIMIT_RST, SPEED_LIMIT_RST, GYRO_LIMIT_RST);
        run_random(100, 35, 1'b0);
        settle_pipeline();
        run_random(100, 35, 1'b0);
        settle_pipeline();

        // Widest limits: standstill on nearly every decision, hold saturates
        apply_settings(1'b1, '1, '1, '1);
        run_random(300, 92, 1'b1);
        settle_pipeline();

        // Detection off: flags frozen while spreads are still reported
        apply_settings(1'b0, '0, '0, '0);
        run_random(100, 40, 1'b0);
        settle_pipeline();

        // Zero limits: standstill can never hold
        apply_settings(1'b1, '0, '0, '0);
        run_random(100, 40, 1'b0);
        settle_pipeline();

        // Random limits near the noise levels used above
        for (int p = 0; p < 3; p++)
        begin
            apply_settings(1'($urandom_range(0, 3) != 0), $urandom_range(0, 60000),
                           $urandom_range(0, 10000), $urandom_range(0, 2000));
            run_random(50, 50, 1'b0);
            settle_pipeline();
        end

        $display("Run covered %0d samples and %0d checked decisions over %0d register settings,",
                 items_sent, decisions_checked, settings_applied);
        $display("including window fill, spread extremes, disabled detection and hold saturation.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
